// ----- sv/fmpd_pkg.sv -----
`default_nettype none

package fmpd_pkg;

    // Default configuration of the top level.
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    // Datapath widths.
    localparam int SCALED_W  = 30;
    localparam int CORDIC_W  = 33;
    localparam int ANGLE_W   = 32;
    localparam int PHASE_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int DEMOD_W   = 16;
    localparam int DIFF_W    = PHASE_W + 1;
    localparam int PROD_W    = DIFF_W + GAIN_W;
    localparam int FRAC_BITS = 12;
    localparam int QUOT_W    = PROD_W + 1 - FRAC_BITS;

    // Angle and rounding constants.
    localparam logic [ANGLE_W-1:0] ANGLE_PI    = ANGLE_W'(1) << (ANGLE_W - 1);
    localparam logic [ANGLE_W-1:0] ANGLE_ROUND = ANGLE_W'(1) << (ANGLE_W - PHASE_W - 1);
    localparam logic [PHASE_W-1:0] PHASE_HALF  = PHASE_W'(1) << (PHASE_W - 1);

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W:0]   PROD_ROUND = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    localparam logic signed [QUOT_W-1:0]  QUOT_MAX  = QUOT_W'((1 << (DEMOD_W - 1)) - 1);
    localparam logic signed [QUOT_W-1:0]  QUOT_MIN  = -QUOT_MAX - QUOT_W'(1);
    localparam logic signed [DEMOD_W-1:0] DEMOD_MAX = {1'b0, {(DEMOD_W - 1){1'b1}}};
    localparam logic signed [DEMOD_W-1:0] DEMOD_MIN = {1'b1, {(DEMOD_W - 1){1'b0}}};

    // Rotation angle of CORDIC iteration k, atan(2^-k), as a 32-bit binary angle.
    function automatic logic [ANGLE_W-1:0] atan_angle(input int k);
        logic [ANGLE_W-1:0] angle;
        case (k)
            0:       angle = 32'h2000_0000;
            1:       angle = 32'h12E4_051E;
            2:       angle = 32'h09FB_385B;
            3:       angle = 32'h0511_11D4;
            4:       angle = 32'h028B_0D43;
            5:       angle = 32'h0145_D7E1;
            6:       angle = 32'h00A2_F61E;
            7:       angle = 32'h0051_7C55;
            8:       angle = 32'h0028_BE53;
            9:       angle = 32'h0014_5F2F;
            10:      angle = 32'h000A_2F98;
            11:      angle = 32'h0005_17CC;
            12:      angle = 32'h0002_8BE6;
            13:      angle = 32'h0001_45F3;
            14:      angle = 32'h0000_A2FA;
            15:      angle = 32'h0000_517D;
            16:      angle = 32'h0000_28BE;
            17:      angle = 32'h0000_145F;
            18:      angle = 32'h0000_0A30;
            19:      angle = 32'h0000_0518;
            20:      angle = 32'h0000_028C;
            21:      angle = 32'h0000_0146;
            22:      angle = 32'h0000_00A3;
            23:      angle = 32'h0000_0051;
            default: angle = '0;
        endcase
        return angle;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fm_phase_discriminator_gain.sv -----
// FM quadrature discriminator: each beat carries one complex sample (I, Q); the block finds
// its phase with a pipelined CORDIC (one register stage per iteration), subtracts the phase
// of the previous sample modulo 2^16 (32768 = pi, difference in (-pi, pi]), multiplies by the
// signed Q4.12 gain, rounds, saturates to 16 bits and returns one result beat per input beat,
// with block_last copied to end_of_block. The pipeline takes one beat per clock while the output
// is not stalled. The input stage loads at the accepting edge, and the beat then passes one
// register stage per CORDIC iteration, then the difference, product and output stages.
// When the output beat is not taken the whole pipeline holds and input ready drops. The gain
// register resets to unity (4096) and the phase history resets to zero.
`default_nettype none

module fm_phase_discriminator_gain #(
    parameter int SAMPLE_WIDTH  = fmpd_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = fmpd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port.
    input  logic                                i_cfg_wr_en,
    input  logic signed [fmpd_pkg::GAIN_W-1:0]  i_cfg_wr_data,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_in_i,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_in_q,
    input  logic                                i_block_last,
    // Output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [fmpd_pkg::DEMOD_W-1:0] o_demod_out,
    output logic                                o_end_of_block
);
    import fmpd_pkg::*;

    localparam int N         = CORDIC_STAGES;
    localparam int PRE_SHIFT = SCALED_W - SAMPLE_WIDTH;
    localparam int OUT_ST    = N + 3;
    localparam int VLD_W     = N + 4;

    // Pipeline control.
    logic              adv;
    logic              in_fire;
    logic [VLD_W-1:0]  r_vld;

    // Configuration and phase history.
    logic signed [GAIN_W-1:0] r_gain;
    logic [PHASE_W-1:0]       r_prev_phase;

    // CORDIC stage registers; index 0 holds the pre-rotated input.
    logic signed [CORDIC_W-1:0] r_x [0:N];
    logic signed [CORDIC_W-1:0] r_y [0:N];
    logic [ANGLE_W-1:0]         r_z [0:N];
    logic                       r_zero [0:N];
    logic                       r_last [0:N];
    logic signed [CORDIC_W-1:0] n_x [0:N];
    logic signed [CORDIC_W-1:0] n_y [0:N];
    logic [ANGLE_W-1:0]         n_z [0:N];

    // Input scaling and pre-rotation.
    logic signed [CORDIC_W-1:0] x_ext;
    logic signed [CORDIC_W-1:0] y_ext;
    logic                       x_neg;

    // Difference, product and output stages.
    logic [ANGLE_W-1:0]        phase_rnd;
    logic [PHASE_W-1:0]        phase;
    logic [PHASE_W-1:0]        phase_dw;
    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [DIFF_W-1:0]  r_diff;
    logic                      r_diff_last;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_last;
    logic signed [PROD_W:0]    prod_sum;
    logic signed [QUOT_W-1:0]  quot;
    logic signed [DEMOD_W-1:0] n_demod;
    logic signed [DEMOD_W-1:0] r_demod;
    logic                      r_out_last;

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv         = !r_vld[OUT_ST] || i_out_ready;
    assign o_in_ready  = i_rst_n && adv;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_vld[OUT_ST];

    // Scale the samples up to the CORDIC width and rotate by pi when I is negative.
    assign x_ext  = {{(CORDIC_W - SAMPLE_WIDTH){i_in_i[SAMPLE_WIDTH-1]}}, i_in_i} <<< PRE_SHIFT;
    assign y_ext  = {{(CORDIC_W - SAMPLE_WIDTH){i_in_q[SAMPLE_WIDTH-1]}}, i_in_q} <<< PRE_SHIFT;
    assign x_neg  = x_ext[CORDIC_W-1];
    assign n_x[0] = x_neg ? -x_ext : x_ext;
    assign n_y[0] = x_neg ? -y_ext : y_ext;
    assign n_z[0] = x_neg ? ANGLE_PI : '0;

    // One CORDIC vectoring iteration per stage, driving Q toward zero.
    for (genvar k = 0; k < N; k++) begin : g_iter
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic                       y_neg;

        assign xs    = r_x[k] >>> k;
        assign ys    = r_y[k] >>> k;
        assign y_neg = r_y[k][CORDIC_W-1];

        assign n_x[k+1] = y_neg ? r_x[k] - ys : r_x[k] + ys;
        assign n_y[k+1] = y_neg ? r_y[k] + xs : r_y[k] - xs;
        assign n_z[k+1] = y_neg ? r_z[k] - atan_angle(k) : r_z[k] + atan_angle(k);
    end

    // Round the accumulated angle to 16 bits; a zero vector has phase zero.
    assign phase_rnd = r_z[N] + ANGLE_ROUND;
    assign phase     = r_zero[N] ? '0 : phase_rnd[ANGLE_W-1 -: PHASE_W];
    assign phase_dw  = phase - r_prev_phase;

    // A difference of exactly pi is taken as +pi.
    assign n_diff = (phase_dw == PHASE_HALF) ? {1'b0, phase_dw} : {phase_dw[PHASE_W-1], phase_dw};

    // Round half up, drop the fraction and saturate to 16 bits.
    assign prod_sum = {r_prod[PROD_W-1], r_prod} + PROD_ROUND;
    assign quot     = prod_sum[PROD_W:FRAC_BITS];
    always_comb begin
        if (quot > QUOT_MAX) begin
            n_demod = DEMOD_MAX;
        end else if (quot < QUOT_MIN) begin
            n_demod = DEMOD_MIN;
        end else begin
            n_demod = quot[DEMOD_W-1:0];
        end
    end

    // Control state: valid bits, gain and phase history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_gain       <= GAIN_RESET;
            r_prev_phase <= '0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[VLD_W-2:0], in_fire};
            end
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
            if (adv && r_vld[N]) begin
                r_prev_phase <= phase;
            end
        end
    end

    // Payload registers of every stage.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= N; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
            r_zero[0] <= (i_in_i == '0) && (i_in_q == '0);
            r_last[0] <= i_block_last;
            for (int k = 1; k <= N; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_last[k] <= r_last[k-1];
            end
            r_diff      <= n_diff;
            r_diff_last <= r_last[N];
            r_prod      <= PROD_W'(r_diff) * PROD_W'(r_gain);
            r_prod_last <= r_diff_last;
            r_demod     <= n_demod;
            r_out_last  <= r_prod_last;
        end
    end

    assign o_demod_out    = r_demod;
    assign o_end_of_block = r_out_last;

endmodule

`default_nettype wire

// ----- sv/fmpd_checker.sv -----
`default_nettype none

module fmpd_checker #(
    parameter int SAMPLE_WIDTH = fmpd_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_wr_en,
    input logic signed [fmpd_pkg::GAIN_W-1:0]  i_cfg_wr_data,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic signed [SAMPLE_WIDTH-1:0]      i_in_i,
    input logic signed [SAMPLE_WIDTH-1:0]      i_in_q,
    input logic                                i_block_last,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [fmpd_pkg::DEMOD_W-1:0] o_demod_out,
    input logic                                o_end_of_block
);

    // A result beat that is not taken stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_demod_out) && $stable(o_end_of_block))
        else $error("output payload changed while stalled");

    // Input is refused only while a result beat waits to be taken.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input refused without output back-pressure");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind fm_phase_discriminator_gain fmpd_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_fmpd_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W     = fmpd_pkg::SAMPLE_WIDTH_DEF;
    localparam int STAGES       = fmpd_pkg::CORDIC_STAGES_DEF;
    localparam int PIPE_LATENCY = STAGES + 4;
    localparam int SAMPLE_SHIFT = 30 - SAMPLE_W;
    localparam real TWO_PI      = 6.28318530717959;

    // Micro-rotation angles atan(2^-k) as 32-bit binary angles.
    localparam logic [31:0] ROT_ANGLE [16] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    typedef struct {
        logic signed [fmpd_pkg::DEMOD_W-1:0] demod;
        logic                                eob;
    } t_demod_beat;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic signed [fmpd_pkg::GAIN_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SAMPLE_W-1:0] in_i = '0;
    logic signed [SAMPLE_W-1:0] in_q = '0;
    logic block_last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [fmpd_pkg::DEMOD_W-1:0] demod_out;
    logic end_of_block;

    // Shadow copy of the block's state and gain register.
    logic signed [fmpd_pkg::GAIN_W-1:0] gain_reg = fmpd_pkg::GAIN_RESET;
    logic [15:0] last_phase = '0;
    t_demod_beat pending_demod[$];
    int error_count = 0;
    int send_idle_pct = 34;
    int recv_stall_pct = 61;
    real phasor_angle = 0.0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    fm_phase_discriminator_gain DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_in_i         (in_i),
        .i_in_q         (in_q),
        .i_block_last   (block_last),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_demod_out    (demod_out),
        .o_end_of_block (end_of_block)
    );

    // Phase of one sample by vectoring CORDIC, rounded to a 16-bit binary angle.
    function automatic logic [15:0] phase_of_sample(logic signed [SAMPLE_W-1:0] si,
                                                    logic signed [SAMPLE_W-1:0] sq);
        longint x;
        longint y;
        longint xs;
        longint ys;
        logic [31:0] z;
        logic [31:0] rounded;
        if (si == 0 && sq == 0) begin
            return 16'h0000;
        end
        x = longint'(si) * (longint'(1) << SAMPLE_SHIFT);
        y = longint'(sq) * (longint'(1) << SAMPLE_SHIFT);
        z = 32'h0000_0000;
        // Left half plane: rotate by pi first.
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int k = 0; k < STAGES; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ROT_ANGLE[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ROT_ANGLE[k];
            end
        end
        rounded = z + 32'h0000_8000;
        return rounded[31:16];
    endfunction

    // Expected output beat for one accepted sample; advances the phase history.
    function automatic t_demod_beat predict_demod(logic signed [SAMPLE_W-1:0] si,
                                                  logic signed [SAMPLE_W-1:0] sq,
                                                  logic last);
        t_demod_beat beat;
        logic [15:0] ph;
        logic [15:0] wrapped;
        longint diff;
        longint scaled;
        ph = phase_of_sample(si, sq);
        wrapped = ph - last_phase;
        diff = longint'($signed(wrapped));
        // A step of exactly pi counts as +pi.
        if (diff == -32768) begin
            diff = 32768;
        end
        scaled = (diff * longint'(gain_reg) + 2048) >>> 12;
        if (scaled > 32767) begin
            scaled = 32767;
        end else if (scaled < -32768) begin
            scaled = -32768;
        end
        last_phase = ph;
        beat.demod = 16'(scaled);
        beat.eob = last;
        return beat;
    endfunction

    // Receiver side: random back-pressure on the output channel.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every output beat with the oldest expected beat.
    always @(posedge clk) begin : check_results
        t_demod_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_demod.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual demod_out=%0d eob=%0b",
                         $time, demod_out, end_of_block);
                error_count++;
            end else begin
                want = pending_demod.pop_front();
                if (demod_out !== want.demod) begin
                    $display("%0t: demod_out mismatch, expected %0d, actual %0d",
                             $time, want.demod, demod_out);
                    error_count++;
                end
                if (end_of_block !== want.eob) begin
                    $display("%0t: end_of_block mismatch, expected %0b, actual %0b",
                             $time, want.eob, end_of_block);
                    error_count++;
                end
            end
        end
    end

    // Send one sample beat after a random idle stretch, and record its expected result.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                               input logic signed [SAMPLE_W-1:0] sq,
                               input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_i <= si;
        in_q <= sq;
        block_last <= last;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        pending_demod.push_back(predict_demod(si, sq, last));
    endtask

    // Stop sending and wait until every expected beat has come out.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_demod.size() != 0) begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_gain(input logic signed [fmpd_pkg::GAIN_W-1:0] g);
        drain_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        gain_reg = g;
    endtask

    function automatic logic [15:0] edge_value();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Half the traffic is a rotating phasor of random amplitude, the rest is random, small or edge-value samples.
    task automatic next_random_sample(output logic signed [SAMPLE_W-1:0] si,
                                      output logic signed [SAMPLE_W-1:0] sq);
        real amp;
        real step;
        if ($urandom_range(1) == 0) begin
            step = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 3.2;
            phasor_angle = phasor_angle + step;
            if (phasor_angle > TWO_PI) begin
                phasor_angle = phasor_angle - TWO_PI;
            end else if (phasor_angle < 0.0) begin
                phasor_angle = phasor_angle + TWO_PI;
            end
            amp = real'($urandom_range(1, 32767));
            si = 16'(int'(amp * $cos(phasor_angle)));
            sq = 16'(int'(amp * $sin(phasor_angle)));
        end else begin
            case ($urandom_range(3))
                0, 1: begin
                    si = 16'($urandom);
                    sq = 16'($urandom);
                end
                2: begin
                    si = 16'(int'($urandom_range(0, 16)) - 8);
                    sq = 16'(int'($urandom_range(0, 16)) - 8);
                end
                default: begin
                    si = edge_value();
                    sq = edge_value();
                end
            endcase
        end
    endtask

    function automatic logic signed [15:0] random_gain();
        case ($urandom_range(3))
            0: return fmpd_pkg::GAIN_RESET;
            1: return 16'(int'($urandom_range(0, 16384)) - 8192);
            2: return 16'($urandom);
            default: return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    // Reset gain: axes, zero vector, steps of exactly pi and sample extremes.
    task automatic test_unity_directed();
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(16'sd16384, 16'sd0, 1'b1);
        send_sample(16'sd0, 16'sd16384, 1'b0);
        send_sample(-16'sd16384, 16'sd0, 1'b1);
        send_sample(16'sd0, -16'sd16384, 1'b0);
        send_sample(16'sd16384, 16'sd0, 1'b0);
        send_sample(-16'sd16384, 16'sd0, 1'b1);
        send_sample(16'sd16384, 16'sd0, 1'b0);
        send_sample(16'sh8000, 16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 16'sh7FFF, 1'b1);
        send_sample(16'sh7FFF, 16'sh8000, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(-16'sd1, -16'sd1, 1'b0);
        send_sample(16'sd1, 16'sd1, 1'b0);
        send_sample(16'sh8000, 16'sd0, 1'b1);
        send_sample(16'sd0, 16'sh8000, 1'b0);
        send_sample(16'sd1, 16'sd0, 1'b0);
        send_sample(-16'sd1, 16'sd0, 1'b1);
        send_sample(16'sd0, 16'sd1, 1'b0);
        send_sample(16'sd0, -16'sd1, 1'b1);
        send_sample(16'sh7FFF, 16'sd0, 1'b0);
    endtask

    // Extreme, small and near-unity gains with quarter-turn, half-turn and arbitrary phase steps.
    task automatic test_gain_extremes();
        logic signed [15:0] gains [7] = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1,
                                           16'sd1, 16'sd4095, -16'sd4096};
        foreach (gains[n]) begin
            write_gain(gains[n]);
            send_sample(16'sd16384, 16'sd0, 1'b0);
            send_sample(16'sd0, 16'sd16384, 1'b1);
            send_sample(16'sd16384, 16'sd0, 1'b0);
            send_sample(-16'sd16384, 16'sd0, 1'b1);
            send_sample(16'sd12000, -16'sd20000, 1'b0);
        end
    endtask

    // Random traffic under one idling pattern, with the gain changed now and then.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                write_gain(random_gain());
            end
            next_random_sample(si, sq);
            send_sample(si, sq, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unity_directed();
        test_gain_extremes();
        test_random_traffic(34, 61, 230);
        test_random_traffic(61, 34, 230);
        test_random_traffic(0, 0, 230);
        drain_pipeline();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/fmpd_pkg.sv
sv/fm_phase_discriminator_gain.sv
sv/fmpd_checker.sv
tb/sv/tb_top.sv
